// ===== hw/rtl/sorted_timer_event_queue_defines.svh =====
// Assertion macros for the sorted timer event queue.
`ifndef SORTED_TIMER_EVENT_QUEUE_DEFINES_SVH
`define SORTED_TIMER_EVENT_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked check, masked while reset is applied
`define STQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check, also live during reset
`define STQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define STQ_ASSERT(lbl, prop, msg)
`define STQ_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== hw/rtl/stq_pkg.sv =====
// Shared types and constants for the sorted timer event queue.
`timescale 1ns / 1ps

package stq_pkg;

	localparam int DEPTH      = 16;
	localparam int ADDR_BITS  = $clog2(DEPTH);
	localparam int CNT_BITS   = $clog2(DEPTH + 1);
	localparam int EVENT_BITS = 8;
	localparam int TIME_BITS  = 48;
	localparam int DELAY_BITS = 16;
	localparam int TPS_BITS   = 20;
	localparam int PROD_BITS  = DELAY_BITS + TPS_BITS;
	localparam int SUM_BITS   = ((TIME_BITS > PROD_BITS) ? TIME_BITS : PROD_BITS) + 1;

	localparam logic [TPS_BITS-1:0]  TPS_RESET = TPS_BITS'(1000);
	localparam logic [TIME_BITS-1:0] TIME_MAX  = {TIME_BITS{1'b1}};

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_SCHED  = 2'd1,
		OP_CANCEL = 2'd2
	} opcode_t;

	typedef enum logic {
		KIND_FIRED   = 1'b0,
		KIND_DROPPED = 1'b1
	} kind_t;

	// Sort key of one queue entry
	typedef struct packed {
		logic [TIME_BITS-1:0]  expiry;
		logic [EVENT_BITS-1:0] ev;
	} slot_key_t;

	// Compare unit results
	typedef struct packed {
		logic le;     // a key at or before b key
		logic ev_eq;  // event ids match
	} cmp_res_t;

endpackage

// ===== hw/rtl/stq_slots.sv =====
// Entry storage: one read port and one write port over the sorted slots.
`timescale 1ns / 1ps

module stq_slots
	import stq_pkg::*;
(
	input  logic                 clk,
	input  logic [ADDR_BITS-1:0] rd_addr,
	output slot_key_t            rd_key,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  slot_key_t            wr_key
);

	slot_key_t slot_q [DEPTH];

	// Write port, no reset: entries past the fill count are never read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_addr] <= wr_key;
		end
	end

	assign rd_key = slot_q[rd_addr];

endmodule

// ===== hw/rtl/stq_cmp.sv =====
// Shared key compare unit used by search, expiry check and cancel match.
`timescale 1ns / 1ps

module stq_cmp
	import stq_pkg::*;
(
	input  slot_key_t a_key,
	input  slot_key_t b_key,
	output cmp_res_t  res
);

	// Lexicographic order on expiry then event id is the order of the packed key
	assign res.le    = (a_key <= b_key);
	assign res.ev_eq = (a_key.ev == b_key.ev);

endmodule

// ===== hw/rtl/stq_expiry.sv =====
// Expiry time: delay times ticks per second, then saturating add of now.
`timescale 1ns / 1ps

module stq_expiry
	import stq_pkg::*;
(
	input  logic                  clk,
	input  logic [DELAY_BITS-1:0] delay,
	input  logic [TPS_BITS-1:0]   tps,
	input  logic [TIME_BITS-1:0]  now,
	output logic [TIME_BITS-1:0]  expiry
);

	logic [PROD_BITS-1:0] prod_s1;
	logic [TIME_BITS-1:0] expiry_s2;
	logic [SUM_BITS-1:0]  sum_w;

	// Stage 1: product
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_BITS'(delay) * PROD_BITS'(tps);
	end

	// Stage 2: add and clamp to the largest time
	assign sum_w = SUM_BITS'(now) + SUM_BITS'(prod_s1);

	always_ff @(posedge clk) begin
		if (sum_w > SUM_BITS'(TIME_MAX)) begin
			expiry_s2 <= TIME_MAX;
		end else begin
			expiry_s2 <= sum_w[TIME_BITS-1:0];
		end
	end

	assign expiry = expiry_s2;

endmodule

// ===== hw/rtl/sorted_timer_event_queue.sv =====
// Top level: sequencer of the sorted timer event queue.
//
//  channel  dir  handshake             payload
//  input    in   in_valid / in_stall   opcode, event_id, delay_secs
//  output   out  out_valid / out_stall fired_event, kind, last
//  config   in   cfg_valid / cfg_ready cfg_data (ticks per second)
//
// After an input transfer, a schedule forms the product and sum, searches for the insert
// position, then opens the gap from the tail and writes; on a full queue it is dropped and
// reported instead. A cancel searches for a matching id, then closes up the gap on a hit.
// A tick checks the front entry until it finds one that has not expired, and closes up after
// each expiry. Reset clears time, count and output; ticks per second returns to 1000. A
// stalled output holds the sequencer in its emit step.
`timescale 1ns / 1ps
`include "sorted_timer_event_queue_defines.svh"

module sorted_timer_event_queue
	import stq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            opcode,
	input  logic [EVENT_BITS-1:0] event_id,
	input  logic [DELAY_BITS-1:0] delay_secs,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [EVENT_BITS-1:0] fired_event,
	output logic                  kind,
	output logic                  last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [TPS_BITS-1:0]   cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_ADD,
		S_FIND,
		S_INS,
		S_DROP,
		S_TICK,
		S_REMOVE,
		S_CANCEL
	} state_t;

	state_t                state_q;
	opcode_t               op_q;
	logic [EVENT_BITS-1:0] ev_q;
	logic [DELAY_BITS-1:0] delay_q;
	logic [TPS_BITS-1:0]   tps_q;
	logic [TIME_BITS-1:0]  time_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [CNT_BITS-1:0]   idx_q;
	logic [CNT_BITS-1:0]   pos_q;
	logic [CNT_BITS-1:0]   j_q;
	logic                  have_pend_q;
	logic [EVENT_BITS-1:0] pend_ev_q;
	logic                  out_valid_q;
	logic [EVENT_BITS-1:0] fired_event_q;
	logic                  kind_q;
	logic                  last_q;

	logic [TIME_BITS-1:0]  expiry_w;
	logic [CNT_BITS-1:0]   rd_addr_w;
	slot_key_t             rd_key_w;
	logic                  wr_en_w;
	logic [CNT_BITS-1:0]   wr_addr_w;
	slot_key_t             wr_key_w;
	slot_key_t             new_key_w;
	slot_key_t             cmp_b_w;
	cmp_res_t              cmp_w;
	logic                  out_free_w;
	logic                  emit_w;
	logic                  hit_w;
	logic                  find_go_w;
	logic                  shift_more_w;

	// Units
	stq_expiry u_expiry (
		.clk    (clk),
		.delay  (delay_q),
		.tps    (tps_q),
		.now    (time_q),
		.expiry (expiry_w)
	);

	stq_slots u_slots (
		.clk     (clk),
		.rd_addr (rd_addr_w[ADDR_BITS-1:0]),
		.rd_key  (rd_key_w),
		.wr_en   (wr_en_w),
		.wr_addr (wr_addr_w[ADDR_BITS-1:0]),
		.wr_key  (wr_key_w)
	);

	stq_cmp u_cmp (
		.a_key (rd_key_w),
		.b_key (cmp_b_w),
		.res   (cmp_w)
	);

	// Compare operand: current time with the largest id for the expiry check, else the new key
	assign new_key_w = '{expiry: expiry_w, ev: ev_q};
	assign cmp_b_w   = (state_q == S_TICK)
	                   ? slot_key_t'{expiry: time_q, ev: {EVENT_BITS{1'b1}}}
	                   : new_key_w;

	assign out_free_w   = !out_valid_q || !out_stall;
	assign emit_w       = out_free_w &&
	                      ((state_q == S_DROP) || ((state_q == S_TICK) && have_pend_q));
	assign hit_w        = (cnt_q != '0) && cmp_w.le;
	assign find_go_w    = (idx_q < cnt_q) && cmp_w.le;
	assign shift_more_w = ((idx_q + 1'b1) < cnt_q);

	// Slot port control
	always_comb begin
		rd_addr_w = '0;
		wr_en_w   = 1'b0;
		wr_addr_w = idx_q;
		wr_key_w  = rd_key_w;
		unique case (state_q)
			S_REMOVE: begin
				rd_addr_w = idx_q + 1'b1;
				wr_en_w   = shift_more_w;
			end
			S_FIND, S_CANCEL: begin
				rd_addr_w = idx_q;
			end
			S_INS: begin
				rd_addr_w = j_q - 1'b1;
				wr_en_w   = 1'b1;
				if (j_q > pos_q) begin
					wr_addr_w = j_q;
				end else begin
					wr_addr_w = pos_q;
					wr_key_w  = new_key_w;
				end
			end
			default: begin
				rd_addr_w = '0;
			end
		endcase
	end

	// Sequencer, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			op_q          <= OP_TICK;
			ev_q          <= '0;
			delay_q       <= '0;
			tps_q         <= TPS_RESET;
			time_q        <= '0;
			cnt_q         <= '0;
			idx_q         <= '0;
			pos_q         <= '0;
			j_q           <= '0;
			have_pend_q   <= 1'b0;
			pend_ev_q     <= '0;
			out_valid_q   <= 1'b0;
			fired_event_q <= '0;
			kind_q        <= 1'b0;
			last_q        <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tps_q <= cfg_data;
			end
			// Output loaded, or taken
			if (emit_w) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= opcode_t'(opcode);
						ev_q    <= event_id;
						delay_q <= delay_secs;
						idx_q   <= '0;
						unique case (opcode_t'(opcode))
							OP_TICK: begin
								if (time_q != TIME_MAX) begin
									time_q <= time_q + 1'b1;
								end
								have_pend_q <= 1'b0;
								state_q     <= S_TICK;
							end
							OP_SCHED:  state_q <= S_MUL;
							OP_CANCEL: state_q <= S_CANCEL;
							default:   state_q <= S_IDLE;
						endcase
					end
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					if (cnt_q == CNT_BITS'(DEPTH)) begin
						state_q <= S_DROP;
					end else begin
						state_q <= S_FIND;
					end
				end
				// Search for the first entry after the new key
				S_FIND: begin
					if (find_go_w) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						pos_q   <= idx_q;
						j_q     <= cnt_q;
						state_q <= S_INS;
					end
				end
				// Open a gap from the tail down, then write the new entry
				S_INS: begin
					if (j_q > pos_q) begin
						j_q <= j_q - 1'b1;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DROP: begin
					if (out_free_w) begin
						fired_event_q <= ev_q;
						kind_q        <= KIND_DROPPED;
						last_q        <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				// Front entry check; one result is held back to mark the last
				S_TICK: begin
					if (hit_w) begin
						if (!have_pend_q) begin
							have_pend_q <= 1'b1;
							pend_ev_q   <= rd_key_w.ev;
							idx_q       <= '0;
							state_q     <= S_REMOVE;
						end else if (out_free_w) begin
							fired_event_q <= pend_ev_q;
							kind_q        <= KIND_FIRED;
							last_q        <= 1'b0;
							pend_ev_q     <= rd_key_w.ev;
							idx_q         <= '0;
							state_q       <= S_REMOVE;
						end
					end else if (!have_pend_q) begin
						state_q <= S_IDLE;
					end else if (out_free_w) begin
						fired_event_q <= pend_ev_q;
						kind_q        <= KIND_FIRED;
						last_q        <= 1'b1;
						have_pend_q   <= 1'b0;
						state_q       <= S_IDLE;
					end
				end
				// Close the gap at idx_q, one entry a cycle
				S_REMOVE: begin
					if (shift_more_w) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= (op_q == OP_TICK) ? S_TICK : S_IDLE;
					end
				end
				S_CANCEL: begin
					if (idx_q >= cnt_q) begin
						state_q <= S_IDLE;
					end else if (cmp_w.ev_eq) begin
						state_q <= S_REMOVE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall    = (state_q != S_IDLE);
	assign cfg_ready   = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign fired_event = fired_event_q;
	assign kind        = kind_q;
	assign last        = last_q;

	// Checks
	`STQ_ASSERT_ALWAYS(a_cnt_range, cnt_q <= CNT_BITS'(DEPTH), "fill count beyond depth")
	`STQ_ASSERT(a_ins_not_full, (state_q == S_INS) |-> (cnt_q < CNT_BITS'(DEPTH)), "full insert")
	`STQ_ASSERT(a_no_pend_idle, (state_q == S_IDLE) |-> !have_pend_q, "held result at idle")
	`STQ_ASSERT(a_idle_cnt, ((state_q == S_IDLE) && !in_valid) |=> $stable(cnt_q), "count moved")

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the sorted timer event queue: predictor, scoreboard and drivers.
`timescale 1ns / 1ps

module tb
	import stq_pkg::*;
();

	localparam logic [1:0] OP_UNUSED = 2'd3;  // not decoded by the block
	localparam int SETTLE_CYCLES = 64;        // covers the longest shift with no result
	localparam int HOLD_CYCLES   = 300;       // long output back-pressure stretch
	localparam longint LIMIT_NS  = 3_000_000;

	// One pending wakeup as the predictor keeps it
	typedef struct {
		logic [TIME_BITS-1:0]  expiry;
		logic [EVENT_BITS-1:0] ev;
	} armed_timer_t;

	// One result transfer
	typedef struct {
		logic [EVENT_BITS-1:0] ev;
		kind_t                 kind;
		logic                  last;
	} wakeup_t;

	// Predictor of the timer queue plus the store of expected wakeups
	class timer_queue_model;
		logic [TIME_BITS-1:0] now_ticks;
		logic [TPS_BITS-1:0]  rate;
		armed_timer_t         armed[$];
		wakeup_t              wakeups_due[$];
		int errors;
		int n_sched, n_tick, n_cancel, n_ignored, n_fired, n_dropped;

		function new();
			now_ticks = '0;
			rate      = TPS_RESET;
			errors    = 0;
			n_sched   = 0;
			n_tick    = 0;
			n_cancel  = 0;
			n_ignored = 0;
			n_fired   = 0;
			n_dropped = 0;
		endfunction

		function void set_rate(logic [TPS_BITS-1:0] val);
			rate = val;
		endfunction

		function int outstanding();
			return wakeups_due.size();
		endfunction

		// Apply one accepted request and queue the wakeups it causes
		function void accept_request(logic [1:0] op, logic [EVENT_BITS-1:0] id,
				logic [DELAY_BITS-1:0] dly);
			logic [SUM_BITS-1:0]  sum;
			logic [TIME_BITS-1:0] exp_time;
			armed_timer_t         ent;
			wakeup_t              w;
			int pos;
			int caused;
			caused = 0;
			case (op)
				OP_TICK: begin
					n_tick++;
					if (now_ticks != TIME_MAX)
						now_ticks = now_ticks + 1'b1;
					while (armed.size() > 0 && armed[0].expiry <= now_ticks && caused < DEPTH) begin
						w.ev   = armed[0].ev;
						w.kind = KIND_FIRED;
						w.last = 1'b0;
						wakeups_due.insert(wakeups_due.size(), w);
						armed.delete(0);
						caused++;
					end
				end
				OP_SCHED: begin
					n_sched++;
					sum = SUM_BITS'(now_ticks) + SUM_BITS'(dly) * SUM_BITS'(rate);
					exp_time = (sum > SUM_BITS'(TIME_MAX)) ? TIME_MAX : sum[TIME_BITS-1:0];
					if (armed.size() >= DEPTH) begin
						w.ev   = id;
						w.kind = KIND_DROPPED;
						w.last = 1'b0;
						wakeups_due.insert(wakeups_due.size(), w);
						caused = 1;
					end else begin
						// after all earlier expiries, and after equal ids (insertion order)
						pos = 0;
						while (pos < armed.size() && (armed[pos].expiry < exp_time ||
								(armed[pos].expiry == exp_time && armed[pos].ev <= id)))
							pos++;
						ent.expiry = exp_time;
						ent.ev     = id;
						armed.insert(pos, ent);
					end
				end
				OP_CANCEL: begin
					n_cancel++;
					for (int i = 0; i < armed.size(); i++) begin
						if (armed[i].ev == id) begin
							armed.delete(i);
							break;
						end
					end
				end
				default: n_ignored++;
			endcase
			if (caused > 0)
				wakeups_due[wakeups_due.size() - 1].last = 1'b1;
		endfunction

		// Compare one result transfer with the oldest expectation
		function void check_wakeup(logic [EVENT_BITS-1:0] ev, logic k, logic l);
			wakeup_t w;
			if (wakeups_due.size() == 0) begin
				$error("result with nothing expected: fired_event=%0d kind=%0d last=%0d",
					ev, k, l);
				errors++;
				return;
			end
			w = wakeups_due[0];
			wakeups_due.delete(0);
			if (w.kind == KIND_FIRED)
				n_fired++;
			else
				n_dropped++;
			if (ev !== w.ev) begin
				$error("fired_event: expected %0d, actual %0d", w.ev, ev);
				errors++;
			end
			if (k !== w.kind) begin
				$error("kind: expected %0d, actual %0d", w.kind, k);
				errors++;
			end
			if (l !== w.last) begin
				$error("last: expected %0d, actual %0d", w.last, l);
				errors++;
			end
		endfunction

		function void final_check();
			if (wakeups_due.size() > 0) begin
				$error("%0d expected results never arrived", wakeups_due.size());
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            opcode;
	logic [EVENT_BITS-1:0] event_id;
	logic [DELAY_BITS-1:0] delay_secs;
	logic                  out_valid;
	logic                  out_stall;
	logic [EVENT_BITS-1:0] fired_event;
	logic                  kind;
	logic                  last;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [TPS_BITS-1:0]   cfg_data;

	timer_queue_model model = new();
	int  hold_req  = 0;   // set by the stimulus, consumed by the receiver
	bit  tx_quiet  = 0;
	int  tx_count  = 0;

	sorted_timer_event_queue u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.event_id    (event_id),
		.delay_secs  (delay_secs),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.fired_event (fired_event),
		.kind        (kind),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#(LIMIT_NS);
		$display("Mismatches found");
		$finish;
	end

	// Receiver: random stalls, quiet stretches, one long hold-off on request
	initial begin : rx_side
		int stall_left;
		int hold_left;
		int res_count;
		bit quiet;
		stall_left = 0;
		hold_left  = 0;
		res_count  = 0;
		quiet      = 0;
		out_stall  = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				model.check_wakeup(fired_event, kind, last);
				res_count++;
				if (res_count % 16 == 0)
					quiet = ($urandom_range(0, 2) == 0);
				stall_left = quiet ? 0 : $urandom_range(0, 4);
			end
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Offer one request and wait for its transfer; entered and left at a falling edge
	task automatic send_item(input logic [1:0] op, input logic [EVENT_BITS-1:0] id,
			input logic [DELAY_BITS-1:0] dly);
		int gap;
		tx_count++;
		if (tx_count % 16 == 0)
			tx_quiet = ($urandom_range(0, 2) == 0);
		gap = tx_quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		opcode     <= op;
		event_id   <= id;
		delay_secs <= dly;
		in_valid   <= 1'b1;
		do @(posedge clk); while (in_stall);
		model.accept_request(op, id, dly);
		@(negedge clk);
	endtask

	// Stop offering until every expected result has come
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (model.outstanding() > 0);
	endtask

	// Idle the block, then write ticks per second
	task automatic write_rate(input logic [TPS_BITS-1:0] val);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		model.set_rate(val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Cancel whatever is still armed
	task automatic flush_armed();
		while (model.armed.size() > 0)
			send_item(OP_CANCEL, model.armed[0].ev, DELAY_BITS'($urandom));
	endtask

	// Random request mix; cancels mostly hit an armed id
	task automatic run_traffic(input int count, input int sched_pct, input int tick_pct,
			input int cancel_pct, input int id_span, input int delay_span);
		int r;
		logic [1:0]            op;
		logic [EVENT_BITS-1:0] id;
		logic [DELAY_BITS-1:0] dly;
		for (int i = 0; i < count; i++) begin
			r   = $urandom_range(0, 99);
			id  = ($urandom_range(0, 9) == 0) ? EVENT_BITS'($urandom)
				: EVENT_BITS'($urandom_range(0, id_span));
			dly = ($urandom_range(0, 19) == 0) ? DELAY_BITS'($urandom)
				: DELAY_BITS'($urandom_range(0, delay_span));
			if (r < sched_pct) begin
				op = OP_SCHED;
			end else if (r < sched_pct + tick_pct) begin
				op = OP_TICK;
			end else if (r < sched_pct + tick_pct + cancel_pct) begin
				op = OP_CANCEL;
				if (model.armed.size() > 0 && $urandom_range(0, 3) != 0)
					id = model.armed[$urandom_range(0, model.armed.size() - 1)].ev;
			end else begin
				op = 2'($urandom_range(0, 3));
			end
			send_item(op, id, dly);
		end
	endtask

	// Stimulus
	initial begin : stimulus
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		opcode     = OP_TICK;
		event_id   = '0;
		delay_secs = '0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset rate: zero delay fires on the next tick, full delay stays armed
		send_item(OP_SCHED, 8'h05, 16'h0000);
		send_item(OP_SCHED, 8'hFF, 16'hFFFF);
		send_item(OP_UNUSED, 8'hAA, 16'h5555);
		send_item(OP_CANCEL, 8'h77, 16'h0000);
		send_item(OP_TICK, 8'h00, 16'h0000);
		send_item(OP_CANCEL, 8'hFF, 16'hAAAA);
		send_item(OP_TICK, 8'hFF, 16'hFFFF);

		// Zero rate: every entry expires now, ties sorted by id then arrival
		write_rate('0);
		send_item(OP_SCHED, 8'd9, 16'd3);
		send_item(OP_SCHED, 8'd2, 16'hFFFF);
		send_item(OP_SCHED, 8'd9, 16'd0);
		send_item(OP_SCHED, 8'd4, 16'd1);
		send_item(OP_CANCEL, 8'd9, 16'd0);
		send_item(OP_TICK, 8'd0, 16'd0);

		// Zero rate under a long output hold-off, with one drain pause midway
		hold_req = HOLD_CYCLES;
		run_traffic(12, 35, 45, 15, 15, 65535);
		wait_drained();
		run_traffic(12, 35, 45, 15, 15, 65535);
		flush_armed();

		// One tick per second: short delays, many ties
		write_rate(20'd1);
		run_traffic(30, 35, 45, 15, 7, 4);
		flush_armed();

		// Largest rate: entries stay armed, the queue fills and drops schedules
		write_rate('1);
		run_traffic(25, 85, 10, 5, 255, 3);
		flush_armed();

		// Small random rate
		write_rate(TPS_BITS'($urandom_range(2, 6)));
		run_traffic(25, 35, 50, 10, 31, 2);
		flush_armed();

		// Fill with near expiries, then ticks release bursts
		write_rate(20'd1);
		run_traffic(18, 70, 20, 5, 63, 1);
		run_traffic(8, 0, 100, 0, 0, 0);
		flush_armed();

		// Back to the reset rate
		write_rate(TPS_RESET);
		run_traffic(10, 40, 40, 15, 15, 3);

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		model.final_check();
		$display("Covered %0d schedules, %0d ticks, %0d cancels, %0d unused-code requests",
			model.n_sched, model.n_tick, model.n_cancel, model.n_ignored);
		$display("  from the reset rate through six rate writes; %0d wakeups, %0d refusals",
			model.n_fired, model.n_dropped);
		if (model.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sorted_timer_event_queue.f =====
+incdir+hw/rtl
hw/rtl/stq_pkg.sv
hw/rtl/stq_slots.sv
hw/rtl/stq_cmp.sv
hw/rtl/stq_expiry.sv
hw/rtl/sorted_timer_event_queue.sv
tb/sv/tb.sv
